// File: hw/rtl/swc_pkg.sv
`default_nettype none

package swc_pkg;

	localparam int DIMENSIONS   = 4;
	localparam int PAIRS        = DIMENSIONS * (DIMENSIONS + 1) / 2;
	localparam int LANES        = PAIRS + DIMENSIONS;
	localparam int WINDOW_DEPTH = 1024;
	localparam int SLOTS        = WINDOW_DEPTH + 1;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 2);
	localparam int IDX_W        = $clog2(PAIRS + 1);
	localparam int ADDR_W       = 5;
	localparam int PT_W         = 32 * DIMENSIONS;

	// Scaled value plus term, before division: 64-bit value times an
	// unsigned count, plus a 64-bit term.
	localparam int SUM_W        = 64 + CNT_W + 1;
	localparam int PH_W         = $clog2(SUM_W + 5);

	localparam logic [2:0] REG_WINDOW_SIZE  = 3'd0;
	localparam logic [2:0] REG_UPDATE_AFTER = 3'd1;
	localparam logic [2:0] REG_INIT_VAR0    = 3'd2;
	localparam logic [2:0] REG_INIT_VAR1    = 3'd3;
	localparam logic [2:0] REG_INIT_VAR2    = 3'd4;
	localparam logic [2:0] REG_INIT_VAR3    = 3'd5;

	localparam logic [10:0] WINDOW_SIZE_RST  = 11'd1024;
	localparam logic [10:0] UPDATE_AFTER_RST = 11'd1024;
	localparam logic [31:0] INIT_VAR_RST     = 32'd65536;

	localparam logic [1:0] ROW_OF [PAIRS] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2,
		2'd2, 2'd3, 2'd3, 2'd3, 2'd3};
	localparam logic [1:0] COL_OF [PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1,
		2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
	localparam logic [IDX_W-1:0] DIAG_OF [DIMENSIONS] = '{4'd0, 4'd2, 4'd5, 4'd9};
	// Bit i is set where entry i lies on the diagonal.
	localparam logic [PAIRS-1:0] DIAG_MASK = 10'b10_0010_0101;

	typedef struct packed {
		logic signed [31:0] coord_3;
		logic signed [31:0] coord_2;
		logic signed [31:0] coord_1;
		logic signed [31:0] coord_0;
	} swc_in_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic [1:0]         col_index;
		logic signed [63:0] covariance;
		logic signed [31:0] row_mean;
		logic               fresh;
		logic               last_entry;
	} swc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_REFRESH,
		ST_READ,
		ST_POP,
		ST_POP_WAIT,
		ST_EMIT
	} swc_state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] mult;
		logic [CNT_W-1:0] div;
		logic             neg_term;
	} lane_ctrl_t;

	typedef struct packed {
		logic             ref_en;
		logic [IDX_W-1:0] ref_idx;
		logic             load_en;
		logic [1:0]       load_row;
	} merge_ctrl_t;

	typedef logic signed [31:0] mean_t;
	typedef logic signed [63:0] moment_t;
	typedef mean_t   [DIMENSIONS-1:0] mean_vec_t;
	typedef moment_t [PAIRS-1:0]      moment_vec_t;

endpackage

`default_nettype wire

// File: hw/rtl/swc_ram.sv
`default_nettype none

module swc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/swc_lane.sv
`default_nettype none

module swc_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire swc_pkg::lane_ctrl_t ctrl,
	input  wire logic signed [31:0]  a,
	input  wire logic signed [31:0]  b,
	input  wire logic                narrow,
	output logic signed [63:0]       value,
	output logic                     idle
);

	import swc_pkg::*;

	localparam logic [PH_W-1:0] PH_PROD      = PH_W'(1);
	localparam logic [PH_W-1:0] PH_SUM       = PH_W'(2);
	localparam logic [PH_W-1:0] PH_ABS       = PH_W'(3);
	localparam logic [PH_W-1:0] PH_DIV_FIRST = PH_W'(4);
	localparam logic [PH_W-1:0] PH_DONE      = PH_W'(4 + SUM_W);

	logic [PH_W-1:0]        phase_q;
	logic signed [63:0]     value_q;
	logic signed [31:0]     a_q, b_q;
	logic [CNT_W-1:0]       mult_q, div_q;
	logic                   neg_term_q, narrow_q, neg_q;
	logic signed [63:0]     prod_s1;
	logic signed [SUM_W-1:0] sum_s2;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       rem_q;

	logic signed [SUM_W-1:0] scaled, term;
	logic [CNT_W:0]         rem_sh;
	logic                   ge;
	logic [CNT_W-1:0]       rem_nx;
	logic                   big, over;
	logic signed [63:0]     r64, res;

	assign scaled = value_q * $signed({1'b0, mult_q});
	assign term   = neg_term_q ? -SUM_W'(prod_s1) : SUM_W'(prod_s1);

	// One quotient bit per step, restoring form.
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_nx = ge ? CNT_W'(rem_sh - {1'b0, div_q}) : CNT_W'(rem_sh);

	always_comb begin
		big = |quo_q[SUM_W-1:64];
		if (neg_q) begin
			over = big | (quo_q[63] & (|quo_q[62:0]));
			r64  = over ? {1'b1, 63'd0} : -$signed(quo_q[63:0]);
		end else begin
			over = big | quo_q[63];
			r64  = over ? {1'b0, {63{1'b1}}} : $signed(quo_q[63:0]);
		end
		res = r64;
		if (narrow_q) begin
			if (r64 > 64'sd2147483647) begin
				res = 64'sd2147483647;
			end else if (r64 < -64'sd2147483648) begin
				res = -64'sd2147483648;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			value_q <= '0;
		end else begin
			if (phase_q == '0) begin
				if (ctrl.start) begin
					phase_q <= PH_PROD;
				end
			end else if (phase_q == PH_DONE) begin
				value_q <= res;
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + PH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == '0 && ctrl.start) begin
			a_q        <= a;
			b_q        <= b;
			mult_q     <= ctrl.mult;
			div_q      <= ctrl.div;
			neg_term_q <= ctrl.neg_term;
			narrow_q   <= narrow;
		end
		if (phase_q == PH_PROD) begin
			prod_s1 <= a_q * b_q;
		end
		if (phase_q == PH_SUM) begin
			sum_s2 <= scaled + term;
		end
		if (phase_q == PH_ABS) begin
			neg_q <= sum_s2[SUM_W-1];
			quo_q <= sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
			rem_q <= '0;
		end
		if (phase_q >= PH_DIV_FIRST && phase_q < PH_DONE) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign value = value_q;
	assign idle  = (phase_q == '0);

endmodule

`default_nettype wire

// File: hw/rtl/swc_merge.sv
`default_nettype none

module swc_merge (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire swc_pkg::merge_ctrl_t       ctrl,
	input  wire swc_pkg::mean_vec_t         means,
	input  wire swc_pkg::moment_vec_t       moments,
	input  wire logic [31:0]                load_val,
	input  wire logic [swc_pkg::IDX_W-1:0]  rd_idx,
	output logic signed [63:0]              cov
);

	import swc_pkg::*;

	logic signed [63:0] cov_q [PAIRS];
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [63:0] prod_s1;
	logic signed [64:0] diff;
	logic signed [63:0] sat;

	assign diff = 65'(moments[idx_s1]) - 65'(prod_s1);
	assign sat  = (diff[64] != diff[63]) ?
		(diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : diff[63:0];

	always_ff @(posedge clk) begin
		prod_s1 <= means[ROW_OF[ctrl.ref_idx]] * means[COL_OF[ctrl.ref_idx]];
		idx_s1  <= ctrl.ref_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < PAIRS; i++) begin
				cov_q[i] <= DIAG_MASK[i] ? {16'd0, INIT_VAR_RST, 16'd0} : 64'sd0;
			end
		end else begin
			vld_s1 <= ctrl.ref_en;
			if (vld_s1) begin
				cov_q[idx_s1] <= sat;
			end
			if (ctrl.load_en) begin
				cov_q[DIAG_OF[ctrl.load_row]] <= {16'd0, load_val, 16'd0};
			end
		end
	end

	assign cov = cov_q[rd_idx];

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_covariance.sv
// Sliding-window covariance of four-coordinate Q16.16 points. Each request
// carries one point; the block answers with ten responses, the lower
// triangle of the covariance matrix row by row, each with its row mean. The
// window lives in a 1025-entry RAM; means and product moments are updated by
// fourteen parallel lanes, each with a 1-bit-per-cycle restoring divider,
// and a merge stage refreshes the covariance with one multiplier, one entry
// a cycle. A point passes through the push update, a covariance refresh when
// one is due or the oldest point leaves the window, the pop update when it
// leaves, and then the responses, one per cycle while the sink is ready.
// Only one point is in flight.
`default_nettype none

module sliding_window_covariance (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [swc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire swc_pkg::swc_in_t            in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output swc_pkg::swc_out_t                out_data
);

	import swc_pkg::*;

	swc_state_t        state_q, state_d;
	logic [10:0]       window_size_q, update_after_q;
	logic [31:0]       init_var_q [DIMENSIONS];
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  occ_q, acc_q;
	logic              do_ref_q, pop_q;
	logic [IDX_W-1:0]  cnt_q;

	logic              cfg_we;
	logic [2:0]        cfg_idx;
	logic              accept;
	logic [CNT_W-1:0]  n_new, acc_nx, eff;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot;
	logic [PT_W-1:0]   rdata;
	logic signed [31:0] src_x [DIMENSIONS];
	logic              lane_start, lane_neg, ram_re, ref_en, lanes_idle;
	lane_ctrl_t        lctrl;
	merge_ctrl_t       mctrl;
	logic signed [63:0] lane_val [LANES];
	logic [LANES-1:0]  lane_idle;
	mean_vec_t         means;
	moment_vec_t       moments;
	logic signed [63:0] cov;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		case (cfg_idx)
			REG_WINDOW_SIZE:  prdata = {21'd0, window_size_q};
			REG_UPDATE_AFTER: prdata = {21'd0, update_after_q};
			REG_INIT_VAR0:    prdata = init_var_q[0];
			REG_INIT_VAR1:    prdata = init_var_q[1];
			REG_INIT_VAR2:    prdata = init_var_q[2];
			REG_INIT_VAR3:    prdata = init_var_q[3];
			default:          prdata = '0;
		endcase
	end

	assign accept = in_valid & in_ready;
	assign n_new  = occ_q + CNT_W'(1);
	assign acc_nx = (acc_q < window_size_q) ? acc_q + CNT_W'(1) : acc_q;

	always_comb begin
		if (window_size_q == '0) begin
			eff = CNT_W'(1);
		end else if (window_size_q > CNT_W'(WINDOW_DEPTH)) begin
			eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			eff = window_size_q;
		end
	end

	assign slot_sum = {1'b0, head_q} + (SLOT_W + 1)'(occ_q);
	assign slot     = (slot_sum >= (SLOT_W + 1)'(SLOTS)) ?
		SLOT_W'(slot_sum - (SLOT_W + 1)'(SLOTS)) : SLOT_W'(slot_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q  <= WINDOW_SIZE_RST;
			update_after_q <= UPDATE_AFTER_RST;
			for (int i = 0; i < DIMENSIONS; i++) begin
				init_var_q[i] <= INIT_VAR_RST;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WINDOW_SIZE:  window_size_q  <= pwdata[10:0];
				REG_UPDATE_AFTER: update_after_q <= pwdata[10:0];
				REG_INIT_VAR0:    init_var_q[0]  <= pwdata;
				REG_INIT_VAR1:    init_var_q[1]  <= pwdata;
				REG_INIT_VAR2:    init_var_q[2]  <= pwdata;
				REG_INIT_VAR3:    init_var_q[3]  <= pwdata;
				default:          ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_PUSH;
			ST_PUSH: begin
				if (lanes_idle) state_d = (do_ref_q | pop_q) ? ST_REFRESH : ST_EMIT;
			end
			ST_REFRESH: begin
				if (cnt_q == IDX_W'(PAIRS)) state_d = pop_q ? ST_READ : ST_EMIT;
			end
			ST_READ:     state_d = ST_POP;
			ST_POP:      state_d = ST_POP_WAIT;
			ST_POP_WAIT: if (lanes_idle) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready && cnt_q == IDX_W'(PAIRS - 1)) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		lane_start = 1'b0;
		lane_neg   = 1'b0;
		ram_re     = 1'b0;
		ref_en     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				lane_start = in_valid;
			end
			ST_REFRESH: ref_en = (cnt_q < IDX_W'(PAIRS));
			ST_READ:    ram_re = 1'b1;
			ST_POP: begin
				lane_start = 1'b1;
				lane_neg   = 1'b1;
			end
			ST_EMIT:    out_valid = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			occ_q    <= '0;
			acc_q    <= '0;
			do_ref_q <= 1'b0;
			pop_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				occ_q    <= n_new;
				acc_q    <= acc_nx;
				do_ref_q <= (acc_nx >= update_after_q);
				pop_q    <= (n_new > eff);
			end
			if (state_q == ST_POP) begin
				occ_q  <= occ_q - CNT_W'(1);
				head_q <= (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
			end
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == ST_REFRESH || (state_q == ST_EMIT && out_ready)) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	swc_ram #(
		.WIDTH(PT_W),
		.DEPTH(SLOTS)
	) u_window (
		.clk   (clk),
		.we    (accept),
		.waddr (slot),
		.wdata (in_data),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (rdata)
	);

	// Lanes take the new point on a push and the oldest point on a pop.
	always_comb begin
		for (int i = 0; i < DIMENSIONS; i++) begin
			src_x[i] = (state_q == ST_POP) ? $signed(rdata[32*i +: 32])
				: $signed(in_data[32*i +: 32]);
		end
	end

	always_comb begin
		lctrl.start    = lane_start;
		lctrl.neg_term = lane_neg;
		if (state_q == ST_POP) begin
			lctrl.mult = occ_q;
			lctrl.div  = occ_q - CNT_W'(1);
		end else begin
			lctrl.mult = occ_q;
			lctrl.div  = n_new;
		end
	end

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		if (j < PAIRS) begin : g_moment
			swc_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (lctrl),
				.a      (src_x[ROW_OF[j]]),
				.b      (src_x[COL_OF[j]]),
				.narrow (1'b0),
				.value  (lane_val[j]),
				.idle   (lane_idle[j])
			);
			assign moments[j] = lane_val[j];
		end else begin : g_mean
			swc_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (lctrl),
				.a      (src_x[j - PAIRS]),
				.b      (32'sd1),
				.narrow (1'b1),
				.value  (lane_val[j]),
				.idle   (lane_idle[j])
			);
			assign means[j - PAIRS] = lane_val[j][31:0];
		end
	end

	assign lanes_idle = &lane_idle;

	assign mctrl.ref_en   = ref_en;
	assign mctrl.ref_idx  = cnt_q;
	assign mctrl.load_en  = cfg_we && cfg_idx >= REG_INIT_VAR0 && cfg_idx <= REG_INIT_VAR3;
	assign mctrl.load_row = 2'(cfg_idx - REG_INIT_VAR0);

	swc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mctrl),
		.means    (means),
		.moments  (moments),
		.load_val (pwdata),
		.rd_idx   (cnt_q),
		.cov      (cov)
	);

	assign out_data.row_index  = ROW_OF[cnt_q];
	assign out_data.col_index  = COL_OF[cnt_q];
	assign out_data.covariance = cov;
	assign out_data.row_mean   = means[ROW_OF[cnt_q]];
	assign out_data.fresh      = do_ref_q | pop_q;
	assign out_data.last_entry = (cnt_q == IDX_W'(PAIRS - 1));

endmodule

`default_nettype wire

// File: hw/rtl/swc_checker.sv
`default_nettype none

module swc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire swc_pkg::swc_out_t           out_data
);

	// A stalled response holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// No new request is taken while responses are being delivered.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request taken during responses");

	// One point at a time: ready drops after a request is taken.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	// Entries stay in the lower triangle.
	a_triangle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.col_index <= out_data.row_index)
		else $error("column above row");

	// Nothing follows the final entry of a point.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_entry |=> !out_valid)
		else $error("response after final entry");

endmodule

bind sliding_window_covariance swc_checker u_swc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import swc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	swc_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	swc_out_t out_data;

	sliding_window_covariance dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state of the covariance estimator.
	logic signed [31:0] win_pts [SLOTS][4];
	int unsigned win_head, win_occ, acc_count;
	int unsigned cfg_window, cfg_update;
	logic signed [31:0] mean_est [4];
	logic signed [63:0] moment_est [PAIRS];
	logic signed [63:0] cov_est [PAIRS];

	swc_in_t point_queue[$];
	swc_out_t entry_queue[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic int pair_at(int r, int c);
		return r * (r + 1) / 2 + c;
	endfunction

	function automatic void enqueue_point(swc_in_t p);
		point_queue = {point_queue, p};
	endfunction

	function automatic logic signed [63:0] sat64(logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (v < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return v[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// (old*mult + term) / div, truncating toward zero.
	function automatic logic signed [63:0] blend(logic signed [63:0] old, int unsigned mult,
			logic signed [127:0] term, int unsigned div);
		logic signed [127:0] o, m, d;
		o = old;
		m = {96'd0, mult};
		d = {96'd0, (div == 0) ? 32'd1 : div};
		return sat64((o * m + term) / d);
	endfunction

	function automatic logic signed [127:0] prod128(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [63:0] wa, wb, p;
		logic signed [127:0] r;
		wa = a;
		wb = b;
		p = wa * wb;
		r = p;
		return r;
	endfunction

	function automatic void refresh_cov();
		logic signed [127:0] mom;
		for (int r = 0; r < DIMENSIONS; r++)
			for (int c = 0; c <= r; c++) begin
				mom = moment_est[pair_at(r, c)];
				cov_est[pair_at(r, c)] = sat64(mom - prod128(mean_est[r], mean_est[c]));
			end
	endfunction

	function automatic void reset_model();
		win_head = 0;
		win_occ = 0;
		acc_count = 0;
		cfg_window = WINDOW_SIZE_RST;
		cfg_update = UPDATE_AFTER_RST;
		for (int i = 0; i < 4; i++) mean_est[i] = '0;
		for (int i = 0; i < PAIRS; i++) begin
			moment_est[i] = '0;
			cov_est[i] = '0;
		end
		for (int i = 0; i < DIMENSIONS; i++)
			cov_est[pair_at(i, i)] = {16'd0, INIT_VAR_RST, 16'd0};
	endfunction

	function automatic void write_model(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_WINDOW_SIZE: cfg_window = val[10:0];
			REG_UPDATE_AFTER: cfg_update = val[10:0];
			REG_INIT_VAR0, REG_INIT_VAR1, REG_INIT_VAR2, REG_INIT_VAR3: begin
				int r;
				r = idx - REG_INIT_VAR0;
				cov_est[pair_at(r, r)] = {16'd0, val, 16'd0};
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_point(swc_in_t pt);
		logic signed [31:0] x [4];
		logic signed [31:0] old [4];
		logic signed [127:0] t;
		int unsigned eff, n, slot;
		bit fresh;
		int cnt;
		swc_out_t e;
		x[0] = pt.coord_0;
		x[1] = pt.coord_1;
		x[2] = pt.coord_2;
		x[3] = pt.coord_3;
		fresh = 0;
		eff = cfg_window;
		if (eff == 0) eff = 1;
		if (eff > WINDOW_DEPTH) eff = WINDOW_DEPTH;
		if (acc_count < cfg_window) acc_count++;
		slot = (win_head + win_occ) % SLOTS;
		for (int i = 0; i < 4; i++) win_pts[slot][i] = x[i];
		win_occ++;
		n = win_occ;
		for (int i = 0; i < DIMENSIONS; i++) begin
			if (n == 1) mean_est[i] = x[i];
			else begin
				t = x[i];
				mean_est[i] = sat32(blend(mean_est[i], n - 1, t, n));
			end
			for (int k = 0; k <= i; k++) begin
				t = prod128(x[i], x[k]);
				if (n == 1) moment_est[pair_at(i, k)] = t[63:0];
				else moment_est[pair_at(i, k)] = blend(moment_est[pair_at(i, k)], n - 1, t, n);
			end
		end
		if (acc_count >= cfg_update) begin
			refresh_cov();
			fresh = 1;
		end
		// Overflow: refresh first, then take the oldest point out.
		if (n > eff) begin
			for (int i = 0; i < 4; i++) old[i] = win_pts[win_head % SLOTS][i];
			refresh_cov();
			fresh = 1;
			for (int i = 0; i < DIMENSIONS; i++) begin
				t = old[i];
				mean_est[i] = sat32(blend(mean_est[i], n, -t, n - 1));
				for (int k = 0; k <= i; k++) begin
					t = prod128(old[i], old[k]);
					moment_est[pair_at(i, k)] = blend(moment_est[pair_at(i, k)], n, -t, n - 1);
				end
			end
			win_head = (win_head + 1) % SLOTS;
			win_occ--;
		end
		cnt = 0;
		for (int i = 0; i < DIMENSIONS; i++)
			for (int k = 0; k <= i; k++) begin
				e.row_index = i[1:0];
				e.col_index = k[1:0];
				e.covariance = cov_est[pair_at(i, k)];
				e.row_mean = mean_est[i];
				e.fresh = fresh;
				e.last_entry = (cnt == PAIRS - 1);
				entry_queue = {entry_queue, e};
				cnt++;
			end
	endfunction

	// Request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_point(in_data);
			if (!in_valid || in_ready) begin
				if (point_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= point_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (entry_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response %p", out_data);
				end else begin
					swc_out_t e;
					e = entry_queue.pop_front();
					if (out_data.row_index !== e.row_index || out_data.col_index !== e.col_index
							|| out_data.covariance !== e.covariance
							|| out_data.row_mean !== e.row_mean || out_data.fresh !== e.fresh
							|| out_data.last_entry !== e.last_entry) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", e, out_data);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		write_model(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (point_queue.size() != 0 || in_valid || entry_queue.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		logic [31:0] pick [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return pick[$urandom_range(0, 3)];
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic void queue_random(int count);
		swc_in_t p;
		repeat (count) begin
			p.coord_0 = rand_coord();
			p.coord_1 = rand_coord();
			p.coord_2 = rand_coord();
			p.coord_3 = rand_coord();
			enqueue_point(p);
		end
	endfunction

	task automatic run_phase(logic [31:0] ws, logic [31:0] ua, int count, int s_idle,
			int r_idle);
		wait_drained();
		reg_write(REG_WINDOW_SIZE, ws);
		reg_write(REG_UPDATE_AFTER, ua);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		queue_random(count);
	endtask

	function automatic swc_in_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		swc_in_t p;
		p.coord_0 = a;
		p.coord_1 = b;
		p.coord_2 = c;
		p.coord_3 = d;
		return p;
	endfunction

	initial begin
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 11;
		recv_idle_pct = 76;

		// Directed points under the reset configuration: zeros, extremes, signs.
		enqueue_point(mk(32'h0, 32'h0, 32'h0, 32'h0));
		enqueue_point(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		enqueue_point(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		enqueue_point(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000));
		enqueue_point(mk(32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h8000_0000));
		enqueue_point(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC));
		enqueue_point(mk(32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000, 32'hFFFE_0000));
		wait_drained();

		// Initial variances include their extremes; the diagonal is loaded on write.
		reg_write(REG_INIT_VAR0, 32'h0);
		reg_write(REG_INIT_VAR1, 32'hFFFF_FFFF);
		reg_write(REG_INIT_VAR2, $urandom);
		reg_write(REG_INIT_VAR3, 32'h1);
		enqueue_point(mk(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h7FFF_FFFF));
		enqueue_point(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		wait_drained();

		// A zero window size behaves as one; an update threshold of zero refreshes always.
		reg_write(REG_WINDOW_SIZE, 32'h0);
		reg_write(REG_UPDATE_AFTER, 32'h0);
		enqueue_point(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		enqueue_point(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		enqueue_point(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
		queue_random(10);

		run_phase(32'd1, 32'd0, 40, 11, 76);
		run_phase(32'd5, 32'd3, 60, 11, 76);
		// Shrinking the window leaves occupancy above the new size for a while.
		run_phase(32'd2, 32'd1024, 30, 76, 11);
		run_phase(32'h7FF, 32'h7FF, 60, 76, 11);
		run_phase(32'd1024, 32'd0, 40, 76, 11);
		wait_drained();
		reg_write(REG_INIT_VAR0, $urandom);
		reg_write(REG_INIT_VAR1, $urandom);
		reg_write(REG_INIT_VAR2, 32'hFFFF_FFFF);
		reg_write(REG_INIT_VAR3, 32'h0);
		run_phase(32'd16, 32'd8, 138, 0, 0);
		run_phase(32'd3, 32'd2, 80, 0, 0);

		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && entry_queue.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/swc_pkg.sv
hw/rtl/swc_ram.sv
hw/rtl/swc_lane.sv
hw/rtl/swc_merge.sv
hw/rtl/sliding_window_covariance.sv
hw/rtl/swc_checker.sv
tb/testbench.sv
